[src/ppmf_pkg.sv]
// Shared types, widths and codes for the filtered pulse period meter.
package ppmf_pkg;

    localparam int CHANNELS      = 2;
    localparam int FRACTION_BITS = 8;

    localparam int CAP_W       = 17;
    localparam int CMAX_W      = 18;
    localparam int CNT_W       = 8;
    localparam int ALPHA_W     = 9;
    localparam int RATIO_W     = 4;
    localparam int PERIOD_W    = 22;
    localparam int ACC_W       = PERIOD_W + FRACTION_BITS;
    localparam int PROD_W      = CNT_W + CMAX_W;
    localparam int END_W       = PROD_W + 1;
    localparam int RL_W        = ACC_W + RATIO_W;
    localparam int STEP_W      = ACC_W + ALPHA_W;
    localparam int ALPHA_SHIFT = 8;
    localparam int ALPHA_ONE   = 256;
    localparam int PERIOD_MAX  = (2 ** PERIOD_W) - 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam int CMDQ_DEPTH = 2;
    localparam int QPTR_W     = $clog2(CMDQ_DEPTH);
    localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_RATIO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_OVERFLOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ODO_DIVIDE       = 3'd4;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 9'd77;
    localparam logic [RATIO_W-1:0] RATIO_RESET   = 4'd10;
    localparam logic [CNT_W-1:0]   TIMEOUT_RESET = 8'd20;
    localparam logic [CMAX_W-1:0]  CMAX_RESET    = 18'd100000;
    localparam logic [CNT_W-1:0]   ODO_RESET     = 8'd3;

    typedef enum logic {
        CMD_EDGE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic                   channel;
        logic [CAP_W-1:0]       capture;
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_START  = 2'd0,
        STAT_ACCEPT = 2'd1,
        STAT_REJECT = 2'd2,
        STAT_TICK   = 2'd3
    } status_t;

    typedef struct packed {
        logic                   channel;
        logic [PERIOD_W-1:0]    period;
        status_t                status;
        logic                   timeout_speed;
        logic                   timeout_tach;
        logic                   odo_pulse;
    } result_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]     alpha;
        logic [RATIO_W-1:0]     ratio;
        logic [CNT_W-1:0]       timeout;
        logic [CMAX_W-1:0]      counter_max;
        logic [CNT_W-1:0]       odo_divide;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SPAN,
        BK_CHECK,
        BK_FILTER
    } back_state_t;

endpackage

[src/ppmf_front.sv]
// Front end: takes input items, decodes them into commands, short command queue.
module ppmf_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      mode,
    input  logic                      channel,
    input  logic [ppmf_pkg::CAP_W-1:0] capture_value,
    output logic                      cmd_valid,
    output ppmf_pkg::cmd_t            cmd,
    input  logic                      cmd_pop
);

    ppmf_pkg::cmd_t                    q_reg [ppmf_pkg::CMDQ_DEPTH];
    logic [ppmf_pkg::QPTR_W-1:0]       head_reg, head_next;
    logic [ppmf_pkg::QPTR_W-1:0]       tail_reg, tail_next;
    logic [ppmf_pkg::QCNT_W-1:0]       count_reg, count_next;
    ppmf_pkg::cmd_t                    cmd_in;
    logic                              push_ok;
    logic                              pop_ok;

    assign full      = (count_reg == ppmf_pkg::QCNT_W'(ppmf_pkg::CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[head_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_pop && cmd_valid;

    // decode: overflow ticks get channel zero; their capture field is not used by the back end
    always_comb
    begin
        cmd_in.kind    = mode ? ppmf_pkg::CMD_TICK : ppmf_pkg::CMD_EDGE;
        cmd_in.channel = mode ? 1'b0 : channel;
        cmd_in.capture = capture_value;
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push_ok)
        begin
            tail_next = (tail_reg == ppmf_pkg::QPTR_W'(ppmf_pkg::CMDQ_DEPTH - 1)) ?
                        '0 : tail_reg + 1'b1;
        end
        if (pop_ok)
        begin
            head_next = (head_reg == ppmf_pkg::QPTR_W'(ppmf_pkg::CMDQ_DEPTH - 1)) ?
                        '0 : head_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[tail_reg] <= cmd_in;
        end
    end

endmodule

[src/ppmf_back.sv]
// Back end: per-channel state, measuring sequencer, filter and result register.
module ppmf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ppmf_pkg::cfg_t     cfg,
    input  logic               cmd_valid,
    input  ppmf_pkg::cmd_t     cmd,
    output logic               cmd_pop,
    output logic               res_valid,
    output ppmf_pkg::result_t  res,
    input  logic               res_pop
);

    ppmf_pkg::back_state_t state_reg, state_next;

    logic                                phase_reg  [ppmf_pkg::CHANNELS];
    logic                                phase_next [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::CAP_W-1:0]          start_reg  [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::CAP_W-1:0]          start_next [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::CNT_W-1:0]          ovf_reg    [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::CNT_W-1:0]          ovf_next   [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::PERIOD_W-1:0]       pout_reg   [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::PERIOD_W-1:0]       pout_next  [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::ACC_W-1:0]          acc_reg    [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::ACC_W-1:0]          acc_next   [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::ACC_W-1:0]          last_reg   [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::ACC_W-1:0]          last_next  [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::CNT_W-1:0]          odo_reg, odo_next;

    // measurement pipeline
    logic                                ch_reg, ch_next;
    logic [ppmf_pkg::CAP_W-1:0]          cap_reg, cap_next;
    logic [ppmf_pkg::PROD_W-1:0]         prod_reg, prod_next;
    logic [ppmf_pkg::RL_W-1:0]           rl_reg, rl_next;
    logic [ppmf_pkg::ACC_W-1:0]          xq_reg, xq_next;
    logic [ppmf_pkg::ACC_W-1:0]          diff_reg, diff_next;
    logic                                ge_reg, ge_next;

    logic                                out_valid_reg, out_valid_next;
    ppmf_pkg::result_t                   out_reg, out_next;

    // combinational helpers
    logic [ppmf_pkg::CNT_W:0]            tick_n   [ppmf_pkg::CHANNELS];
    logic                                tick_out [ppmf_pkg::CHANNELS];
    logic [ppmf_pkg::CNT_W:0]            odo_inc;
    logic                                odo_hit;
    logic [ppmf_pkg::RATIO_W-1:0]        ratio_eff;
    logic [ppmf_pkg::ALPHA_W-1:0]        alpha_eff;
    logic [ppmf_pkg::END_W-1:0]          end_time;
    logic [ppmf_pkg::END_W-1:0]          raw;
    logic [ppmf_pkg::PERIOD_W-1:0]       raw_sat;
    logic [ppmf_pkg::STEP_W-1:0]         step_full;
    logic [ppmf_pkg::ACC_W-1:0]          step;
    logic [ppmf_pkg::ACC_W-1:0]          acc_new;
    logic                                idle_take;

    assign cmd_pop   = idle_take;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign idle_take = (state_reg == ppmf_pkg::BK_IDLE) && cmd_valid && !out_valid_reg;

    assign ratio_eff = (cfg.ratio == '0) ? ppmf_pkg::RATIO_W'(1) : cfg.ratio;
    assign alpha_eff = (cfg.alpha > ppmf_pkg::ALPHA_W'(ppmf_pkg::ALPHA_ONE)) ?
                       ppmf_pkg::ALPHA_W'(ppmf_pkg::ALPHA_ONE) : cfg.alpha;

    assign odo_inc = {1'b0, odo_reg} + 1'b1;
    assign odo_hit = (odo_inc >= {1'b0, cfg.odo_divide});

    always_comb
    begin
        for (int i = 0; i < ppmf_pkg::CHANNELS; i++)
        begin
            tick_n[i]   = {1'b0, ovf_reg[i]} + 1'b1;
            tick_out[i] = (tick_n[i] > {1'b0, cfg.timeout});
        end
    end

    // span arithmetic: end + overflows*counter_max - start, clamped and saturated
    always_comb
    begin
        end_time = ppmf_pkg::END_W'(cap_reg) + ppmf_pkg::END_W'(prod_reg);
        if (end_time > ppmf_pkg::END_W'(start_reg[ch_reg]))
        begin
            raw = end_time - ppmf_pkg::END_W'(start_reg[ch_reg]);
        end
        else
        begin
            raw = '0;
        end
        if (raw > ppmf_pkg::END_W'(ppmf_pkg::PERIOD_MAX))
        begin
            raw_sat = ppmf_pkg::PERIOD_W'(ppmf_pkg::PERIOD_MAX);
        end
        else
        begin
            raw_sat = raw[ppmf_pkg::PERIOD_W-1:0];
        end
    end

    // filter step, truncated toward the old value
    assign step_full = ppmf_pkg::STEP_W'(alpha_eff) * ppmf_pkg::STEP_W'(diff_reg);
    assign step      = step_full[ppmf_pkg::ALPHA_SHIFT +: ppmf_pkg::ACC_W];
    assign acc_new   = ge_reg ? (acc_reg[ch_reg] + step) : (acc_reg[ch_reg] - step);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        start_next     = start_reg;
        ovf_next       = ovf_reg;
        pout_next      = pout_reg;
        acc_next       = acc_reg;
        last_next      = last_reg;
        odo_next       = odo_reg;
        ch_next        = ch_reg;
        cap_next       = cap_reg;
        prod_next      = prod_reg;
        rl_next        = rl_reg;
        xq_next        = xq_reg;
        diff_next      = diff_reg;
        ge_next        = ge_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (res_pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ppmf_pkg::BK_IDLE:
            begin
                if (idle_take)
                begin
                    out_next.timeout_speed = 1'b0;
                    out_next.timeout_tach  = 1'b0;
                    out_next.odo_pulse     = 1'b0;
                    if (cmd.kind == ppmf_pkg::CMD_TICK)
                    begin
                        for (int i = 0; i < ppmf_pkg::CHANNELS; i++)
                        begin
                            if (tick_out[i])
                            begin
                                ovf_next[i]   = '0;
                                pout_next[i]  = '0;
                                phase_next[i] = 1'b0;
                            end
                            else
                            begin
                                ovf_next[i] = tick_n[i][ppmf_pkg::CNT_W-1:0];
                            end
                        end
                        out_next.channel       = 1'b0;
                        out_next.period        = tick_out[0] ? '0 : pout_reg[0];
                        out_next.status        = ppmf_pkg::STAT_TICK;
                        out_next.timeout_speed = tick_out[0];
                        out_next.timeout_tach  = tick_out[1];
                        out_valid_next         = 1'b1;
                    end
                    else if (!phase_reg[cmd.channel])
                    begin
                        start_next[cmd.channel] = cmd.capture;
                        ovf_next[cmd.channel]   = '0;
                        phase_next[cmd.channel] = 1'b1;
                        if (cmd.channel == 1'b0)
                        begin
                            odo_next           = odo_hit ? '0 : odo_inc[ppmf_pkg::CNT_W-1:0];
                            out_next.odo_pulse = odo_hit;
                        end
                        out_next.channel = cmd.channel;
                        out_next.period  = pout_reg[cmd.channel];
                        out_next.status  = ppmf_pkg::STAT_START;
                        out_valid_next   = 1'b1;
                    end
                    else
                    begin
                        ch_next    = cmd.channel;
                        cap_next   = cmd.capture;
                        prod_next  = ppmf_pkg::PROD_W'(ovf_reg[cmd.channel]) *
                                     ppmf_pkg::PROD_W'(cfg.counter_max);
                        rl_next    = ppmf_pkg::RL_W'(ratio_eff) *
                                     ppmf_pkg::RL_W'(last_reg[cmd.channel]);
                        state_next = ppmf_pkg::BK_SPAN;
                    end
                end
            end

            ppmf_pkg::BK_SPAN:
            begin
                xq_next    = {raw_sat, ppmf_pkg::FRACTION_BITS'(0)};
                state_next = ppmf_pkg::BK_CHECK;
            end

            ppmf_pkg::BK_CHECK:
            begin
                phase_next[ch_reg] = 1'b0;
                ovf_next[ch_reg]   = '0;
                if (ppmf_pkg::RL_W'(xq_reg) > rl_reg)
                begin
                    out_next.channel = ch_reg;
                    out_next.period  = pout_reg[ch_reg];
                    out_next.status  = ppmf_pkg::STAT_REJECT;
                    if (ch_reg == 1'b0)
                    begin
                        odo_next           = odo_hit ? '0 : odo_inc[ppmf_pkg::CNT_W-1:0];
                        out_next.odo_pulse = odo_hit;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ppmf_pkg::BK_IDLE;
                end
                else
                begin
                    ge_next    = (xq_reg >= acc_reg[ch_reg]);
                    diff_next  = (xq_reg >= acc_reg[ch_reg]) ? (xq_reg - acc_reg[ch_reg]) :
                                 (acc_reg[ch_reg] - xq_reg);
                    state_next = ppmf_pkg::BK_FILTER;
                end
            end

            ppmf_pkg::BK_FILTER:
            begin
                acc_next[ch_reg]  = acc_new;
                last_next[ch_reg] = acc_new;
                pout_next[ch_reg] = acc_new[ppmf_pkg::FRACTION_BITS +: ppmf_pkg::PERIOD_W];
                out_next.channel  = ch_reg;
                out_next.period   = acc_new[ppmf_pkg::FRACTION_BITS +: ppmf_pkg::PERIOD_W];
                out_next.status   = ppmf_pkg::STAT_ACCEPT;
                if (ch_reg == 1'b0)
                begin
                    odo_next           = odo_hit ? '0 : odo_inc[ppmf_pkg::CNT_W-1:0];
                    out_next.odo_pulse = odo_hit;
                end
                out_valid_next = 1'b1;
                state_next     = ppmf_pkg::BK_IDLE;
            end

            default:
            begin
                state_next = ppmf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppmf_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ppmf_pkg::CHANNELS; i++)
            begin
                phase_reg[i] <= 1'b0;
                start_reg[i] <= '0;
                ovf_reg[i]   <= '0;
                pout_reg[i]  <= '0;
                acc_reg[i]   <= '0;
                last_reg[i]  <= '1;
            end
            odo_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            ovf_reg       <= ovf_next;
            pout_reg      <= pout_next;
            acc_reg       <= acc_next;
            last_reg      <= last_next;
            odo_reg       <= odo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        cap_reg  <= cap_next;
        prod_reg <= prod_next;
        rl_reg   <= rl_next;
        xq_reg   <= xq_next;
        diff_reg <= diff_next;
        ge_reg   <= ge_next;
        out_reg  <= out_next;
    end

endmodule

[src/pulse_period_meter_filtered_top.sv]
// Top level of the two-channel filtered pulse period meter.
// Path, push to result: a tick or a start edge passes the command queue and the result
// register; a closing edge also passes the SPAN and CHECK steps, and FILTER if accepted.
// The back-end sequencer takes no new transaction until it is back in IDLE and its one
// result register has been popped.
// Reset (rst_n low, async): queues empty, channels idle, filters 0, regs 77/10/20/100000/3.
module pulse_period_meter_filtered_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // input queue side
    input  logic                            push,
    output logic                            full,
    input  logic                            mode,
    input  logic                            channel,
    input  logic [ppmf_pkg::CAP_W-1:0]      capture_value,
    // result queue side
    output logic                            empty,
    input  logic                            pop,
    output logic                            out_channel,
    output logic [ppmf_pkg::PERIOD_W-1:0]   period_filtered,
    output logic [1:0]                      status,
    output logic                            timeout_speed,
    output logic                            timeout_tach,
    output logic                            odo_pulse,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ppmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppmf_pkg::CFG_DATA_W-1:0] cfg_data
);

    ppmf_pkg::cfg_t     cfg_reg, cfg_next;
    ppmf_pkg::cmd_t     cmd;
    logic               cmd_valid;
    logic               cmd_pop;
    logic               res_valid;
    ppmf_pkg::result_t  res;

    // Configuration: always ready; the user must write it only while the meter is idle (not enforced).
    // Indexes past the register list are accepted and dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ppmf_pkg::REG_FILTER_ALPHA:
                    cfg_next.alpha = cfg_data[ppmf_pkg::ALPHA_W-1:0];
                ppmf_pkg::REG_OUTLIER_RATIO:
                    cfg_next.ratio = cfg_data[ppmf_pkg::RATIO_W-1:0];
                ppmf_pkg::REG_TIMEOUT_OVERFLOW:
                    cfg_next.timeout = cfg_data[ppmf_pkg::CNT_W-1:0];
                ppmf_pkg::REG_COUNTER_MAX:
                    cfg_next.counter_max = cfg_data[ppmf_pkg::CMAX_W-1:0];
                ppmf_pkg::REG_ODO_DIVIDE:
                    cfg_next.odo_divide = cfg_data[ppmf_pkg::CNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha       <= ppmf_pkg::ALPHA_RESET;
            cfg_reg.ratio       <= ppmf_pkg::RATIO_RESET;
            cfg_reg.timeout     <= ppmf_pkg::TIMEOUT_RESET;
            cfg_reg.counter_max <= ppmf_pkg::CMAX_RESET;
            cfg_reg.odo_divide  <= ppmf_pkg::ODO_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: decodes each transaction and buffers it in a two-entry queue, so input
    // keeps flowing while the back end measures or a result waits, until that queue is full.
    ppmf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .channel       (channel),
        .capture_value (capture_value),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    // Back end: channel state, span multiply, outlier check, EMA filter.
    ppmf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    // Result register presented as the head of an output queue.
    assign empty           = !res_valid;
    assign out_channel     = res.channel;
    assign period_filtered = res.period;
    assign status          = res.status;
    assign timeout_speed   = res.timeout_speed;
    assign timeout_tach    = res.timeout_tach;
    assign odo_pulse       = res.odo_pulse;

endmodule

[tb/ppmf_checker.sv]
// Checker for the filtered pulse period meter: tracks channels, predicts and compares results.
`timescale 1ns / 1ps

module ppmf_checker
    import ppmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic                  mode,
    input  logic                  channel,
    input  logic [CAP_W-1:0]      capture_value,
    input  logic                  empty,
    input  logic                  pop,
    input  logic                  out_channel,
    input  logic [PERIOD_W-1:0]   period_filtered,
    input  logic [1:0]            status,
    input  logic                  timeout_speed,
    input  logic                  timeout_tach,
    input  logic                  odo_pulse,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    n_checked,
    output int                    n_accept,
    output int                    n_reject,
    output int                    n_timeout
);

    // register copies
    logic [ALPHA_W-1:0]  alpha_r;
    logic [RATIO_W-1:0]  ratio_r;
    logic [CNT_W-1:0]    tmo_r;
    logic [CMAX_W-1:0]   cmax_r;
    logic [CNT_W-1:0]    odo_div_r;

    // per-channel meter state
    logic                phase     [CHANNELS];
    logic [CAP_W-1:0]    start_t   [CHANNELS];
    logic [CNT_W-1:0]    ovf_cnt   [CHANNELS];
    logic [PERIOD_W-1:0] per_out   [CHANNELS];
    logic [ACC_W-1:0]    acc_r     [CHANNELS];
    logic [ACC_W-1:0]    last_acc  [CHANNELS];
    logic [CNT_W-1:0]    odo_cnt;

    result_t readings_due[$];

    task automatic predict_reading(input logic is_tick, input logic ch,
                                   input logic [CAP_W-1:0] cap, output result_t r);
        logic [CNT_W:0] n;
        logic [63:0]    span_end;
        logic [63:0]    raw;
        logic [63:0]    xq;
        logic [63:0]    ratio_eff;
        logic [63:0]    lim;
        logic [63:0]    wt;
        logic [63:0]    acc;
        int             i;
        r = '0;
        if (is_tick)
        begin
            for (i = 0; i < CHANNELS; i++)
            begin
                n = {1'b0, ovf_cnt[i]} + 1'b1;
                if (n > {1'b0, tmo_r})
                begin
                    ovf_cnt[i] = '0;
                    per_out[i] = '0;
                    phase[i]   = 1'b0;
                    if (i == 0)
                        r.timeout_speed = 1'b1;
                    else
                        r.timeout_tach  = 1'b1;
                end
                else
                begin
                    ovf_cnt[i] = n[CNT_W-1:0];
                end
            end
            r.status = STAT_TICK;
            r.period = per_out[0];
        end
        else
        begin
            r.channel = ch;
            if (!phase[ch])
            begin
                start_t[ch] = cap;
                ovf_cnt[ch] = '0;
                phase[ch]   = 1'b1;
                r.status    = STAT_START;
            end
            else
            begin
                span_end = 64'(cap) + 64'(ovf_cnt[ch]) * 64'(cmax_r);
                raw = (span_end > 64'(start_t[ch])) ? span_end - 64'(start_t[ch]) : 64'd0;
                if (raw > 64'(PERIOD_MAX))
                    raw = 64'(PERIOD_MAX);
                phase[ch]   = 1'b0;
                ovf_cnt[ch] = '0;
                xq = raw << FRACTION_BITS;
                ratio_eff = (ratio_r == '0) ? 64'd1 : 64'(ratio_r);
                lim = ratio_eff * 64'(last_acc[ch]);
                if (xq > lim)
                begin
                    r.status = STAT_REJECT;
                end
                else
                begin
                    wt  = (alpha_r > ALPHA_W'(ALPHA_ONE)) ? 64'(ALPHA_ONE) : 64'(alpha_r);
                    acc = 64'(acc_r[ch]);
                    if (xq >= acc)
                        acc = acc + ((wt * (xq - acc)) >> ALPHA_SHIFT);
                    else
                        acc = acc - ((wt * (acc - xq)) >> ALPHA_SHIFT);
                    acc_r[ch]    = acc[ACC_W-1:0];
                    last_acc[ch] = acc[ACC_W-1:0];
                    per_out[ch]  = acc[ACC_W-1:FRACTION_BITS];
                    r.status     = STAT_ACCEPT;
                end
            end
            if (ch == 1'b0)
            begin
                n = {1'b0, odo_cnt} + 1'b1;
                if (n >= {1'b0, odo_div_r})
                begin
                    odo_cnt     = '0;
                    r.odo_pulse = 1'b1;
                end
                else
                begin
                    odo_cnt = n[CNT_W-1:0];
                end
            end
            r.period = per_out[ch];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        result_t fresh;
        int      i;
        if (!rst_n)
        begin
            alpha_r    = ALPHA_RESET;
            ratio_r    = RATIO_RESET;
            tmo_r      = TIMEOUT_RESET;
            cmax_r     = CMAX_RESET;
            odo_div_r  = ODO_RESET;
            for (i = 0; i < CHANNELS; i++)
            begin
                phase[i]    = 1'b0;
                start_t[i]  = '0;
                ovf_cnt[i]  = '0;
                per_out[i]  = '0;
                acc_r[i]    = '0;
                last_acc[i] = '1;
            end
            odo_cnt    = '0;
            readings_due.delete();
            fail_count = 0;
            pending    = 0;
            n_checked  = 0;
            n_accept   = 0;
            n_reject   = 0;
            n_timeout  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FILTER_ALPHA:     alpha_r   = cfg_data[ALPHA_W-1:0];
                    REG_OUTLIER_RATIO:    ratio_r   = cfg_data[RATIO_W-1:0];
                    REG_TIMEOUT_OVERFLOW: tmo_r     = cfg_data[CNT_W-1:0];
                    REG_COUNTER_MAX:      cmax_r    = cfg_data[CMAX_W-1:0];
                    REG_ODO_DIVIDE:       odo_div_r = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            // result side first: a result popped now can never belong to this edge's push
            if (pop && !empty)
            begin
                got.channel       = out_channel;
                got.period        = period_filtered;
                got.status        = status_t'(status);
                got.timeout_speed = timeout_speed;
                got.timeout_tach  = timeout_tach;
                got.odo_pulse     = odo_pulse;
                n_checked++;
                if (readings_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result: ch=%0d period=%0d st=%0d",
                                 $time, got.channel, got.period, got.status);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (got.channel !== want.channel || got.period !== want.period ||
                        got.status !== want.status ||
                        got.timeout_speed !== want.timeout_speed ||
                        got.timeout_tach !== want.timeout_tach ||
                        got.odo_pulse !== want.odo_pulse)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch expected ch=%0d period=%0d st=%0d",
                                     $time, want.channel, want.period, want.status);
                            $display("          ts=%0d tt=%0d odo=%0d",
                                     want.timeout_speed, want.timeout_tach, want.odo_pulse);
                            $display("          actual   ch=%0d period=%0d st=%0d",
                                     got.channel, got.period, got.status);
                            $display("          ts=%0d tt=%0d odo=%0d",
                                     got.timeout_speed, got.timeout_tach, got.odo_pulse);
                        end
                    end
                end
            end
            if (push && !full)
            begin
                predict_reading(mode, channel, capture_value, fresh);
                if (fresh.status == STAT_ACCEPT)
                    n_accept++;
                if (fresh.status == STAT_REJECT)
                    n_reject++;
                if (fresh.timeout_speed || fresh.timeout_tach)
                    n_timeout++;
                readings_due.push_back(fresh);
            end
            pending = readings_due.size();
        end
    end

endmodule

[tb/tb_pulse_period_meter_filtered_top.sv]
// Testbench top for the filtered pulse period meter: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_pulse_period_meter_filtered_top;
    import ppmf_pkg::*;

    localparam logic SPEED = 1'b0;
    localparam logic TACH  = 1'b1;

    // cycles with no transaction on any channel before the run is declared hung
    localparam int HANG_LIMIT   = 5000;
    // settling wait after the last result is back, before touching registers
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 245;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic                  mode;
    logic                  channel;
    logic [CAP_W-1:0]      capture_value;
    logic                  empty;
    logic                  pop;
    logic                  out_channel;
    logic [PERIOD_W-1:0]   period_filtered;
    logic [1:0]            status;
    logic                  timeout_speed;
    logic                  timeout_tach;
    logic                  odo_pulse;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int n_checked;
    int n_accept;
    int n_reject;
    int n_timeout;

    // idling knobs: percent of cycles the sender holds off / the receiver stalls
    int idle_pct;
    int stall_pct;
    int cur_timeout;
    int n_items;
    int n_settings;

    pulse_period_meter_filtered_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .mode            (mode),
        .channel         (channel),
        .capture_value   (capture_value),
        .empty           (empty),
        .pop             (pop),
        .out_channel     (out_channel),
        .period_filtered (period_filtered),
        .status          (status),
        .timeout_speed   (timeout_speed),
        .timeout_tach    (timeout_tach),
        .odo_pulse       (odo_pulse),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    ppmf_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .mode            (mode),
        .channel         (channel),
        .capture_value   (capture_value),
        .empty           (empty),
        .pop             (pop),
        .out_channel     (out_channel),
        .period_filtered (period_filtered),
        .status          (status),
        .timeout_speed   (timeout_speed),
        .timeout_tach    (timeout_tach),
        .odo_pulse       (odo_pulse),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .n_checked       (n_checked),
        .n_accept        (n_accept),
        .n_reject        (n_reject),
        .n_timeout       (n_timeout)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: decides pop once per falling edge, so pop only ever gets one update per step.
    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: any accepted transaction on any channel restarts the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // Sends one item. Entered and left at a falling edge; push stays high on return so
    // back-to-back items need no lowering in between.
    task automatic send_item(input cmd_kind_t kind, input logic ch, input logic [CAP_W-1:0] cap);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push          <= 1'b1;
        mode          <= kind;
        channel       <= ch;
        capture_value <= cap;
        do
            @(posedge clk);
        while (full);
        n_items++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 1'($urandom_range(0, 1)),
                  CAP_W'($urandom_range(0, 2 ** CAP_W - 1)));
    endtask

    // Holds the sender until every expected result is back, then lets the back end settle.
    task automatic drain();
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Writes all five registers; caller has already drained the block.
    task automatic program_meter(input int alpha, input int ratio, input int tmo,
                                 input int cmax, input int odo);
        cfg_write(REG_FILTER_ALPHA, alpha);
        cfg_write(REG_OUTLIER_RATIO, ratio);
        cfg_write(REG_TIMEOUT_OVERFLOW, tmo);
        cfg_write(REG_COUNTER_MAX, cmax);
        cfg_write(REG_ODO_DIVIDE, odo);
        cfg_valid   <= 1'b0;
        cur_timeout = tmo;
        n_settings++;
    endtask

    task automatic set_idling(input int kind);
        case (kind)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 81;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 81;
            end
            default:
            begin
                idle_pct  = 7;
                stall_pct = 7;
            end
        endcase
    endtask

    // Random traffic, mostly start/ticks/close sequences with random content, plus tick
    // bursts that push channels into timeout and stray edges that break the pairing.
    task automatic run_random(input int target);
        int          first;
        int          pick;
        int          nt;
        int          burst_max;
        int          k;
        logic        ch;
        logic [CAP_W-1:0] s;
        logic [CAP_W-1:0] e;
        first = n_items;
        burst_max = (cur_timeout + 3 > 40) ? 40 : cur_timeout + 3;
        while (n_items - first < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                ch = 1'($urandom_range(0, 1));
                s  = CAP_W'($urandom_range(0, 2 ** CAP_W - 1));
                send_item(CMD_EDGE, ch, s);
                if ($urandom_range(0, 3) == 0)
                    nt = $urandom_range(0, burst_max);
                else
                    nt = $urandom_range(0, 2);
                for (k = 0; k < nt; k++)
                begin
                    // the other channel occasionally fires in the middle of this pair
                    if ($urandom_range(0, 9) == 0)
                        send_item(CMD_EDGE, ~ch, CAP_W'($urandom_range(0, 2 ** CAP_W - 1)));
                    send_tick();
                end
                case ($urandom_range(0, 3))
                    0, 1: e = s + CAP_W'($urandom_range(0, 4000));
                    2:    e = CAP_W'($urandom_range(0, 2 ** CAP_W - 1));
                    default: e = s - CAP_W'($urandom_range(0, 300));
                endcase
                send_item(CMD_EDGE, ch, e);
            end
            else if (pick < 85)
            begin
                nt = $urandom_range(1, burst_max);
                for (k = 0; k < nt; k++)
                    send_tick();
            end
            else
            begin
                send_item(CMD_EDGE, 1'($urandom_range(0, 1)),
                          CAP_W'($urandom_range(0, 2 ** CAP_W - 1)));
            end
            // now and then the sender waits for the result queue to run dry
            if ($urandom_range(0, 63) == 0)
                drain();
        end
    endtask

    initial
    begin : stimulus
        int p;
        rst_n         = 1'b0;
        push          = 1'b0;
        mode          = CMD_EDGE;
        channel       = SPEED;
        capture_value = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_FILTER_ALPHA;
        cfg_data      = '0;
        n_items       = 0;
        n_settings    = 1;
        cur_timeout   = int'(TIMEOUT_RESET);
        set_idling(0);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed, reset register values.
        send_tick();                          // tick with nothing measured yet
        send_item(CMD_EDGE, SPEED, '0);       // start at timer zero
        send_item(CMD_EDGE, SPEED, '1);       // close at timer max, first acceptance
        send_item(CMD_EDGE, SPEED, 17'd5);
        send_item(CMD_EDGE, SPEED, 17'd1);    // end before start: period clamps to zero
        send_item(CMD_EDGE, TACH, '1);
        send_item(CMD_EDGE, TACH, '0);        // zero period accepted, tach filter stays at zero
        send_item(CMD_EDGE, TACH, 17'd100);
        send_item(CMD_EDGE, TACH, 17'd200);   // anything above a zero filter is an outlier
        send_item(CMD_EDGE, SPEED, 17'd90000);
        send_tick();
        send_tick();
        send_item(CMD_EDGE, SPEED, 17'd1000); // span across two overflows
        drain();

        // Directed, out-of-range register values: alpha above one, ratio zero, timeout zero,
        // zero counter length, odometer divide zero.
        program_meter(511, 0, 0, 0, 0);
        send_tick();                          // timeout zero: both channels drop out
        send_item(CMD_EDGE, SPEED, 17'd1000);
        send_item(CMD_EDGE, SPEED, 17'd1500); // full-weight filter jumps to the sample
        send_item(CMD_EDGE, SPEED, 17'd0);
        send_item(CMD_EDGE, SPEED, 17'd600);  // above one times last: rejected
        send_item(CMD_EDGE, TACH, 17'd10);
        send_tick();                          // timeout puts tach back to awaiting start
        send_item(CMD_EDGE, TACH, 17'd50);
        send_item(CMD_EDGE, TACH, 17'd40);
        drain();

        // Random phases: high extremes, low extremes, reset values, then random settings.
        for (p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                program_meter(ALPHA_ONE, 15, 255, 131072, 1);
            else if (p == 1)
                program_meter(0, 1, 1, 1, 255);
            else if (p == 2)
                program_meter(int'(ALPHA_RESET), int'(RATIO_RESET), int'(TIMEOUT_RESET),
                              int'(CMAX_RESET), int'(ODO_RESET));
            else
                program_meter($urandom_range(0, 511), $urandom_range(0, 15),
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 12),
                              $urandom_range(0, 2 ** CMAX_W - 1), $urandom_range(0, 8));
            set_idling(p % 4);
            run_random(PHASE_ITEMS);
            set_idling(0);
            drain();
        end

        $display("Run covered %0d items over %0d register settings and four idling patterns.",
                 n_items, n_settings);
        $display("Results checked %0d: %0d accepted, %0d rejected, %0d ticks with a timeout.",
                 n_checked, n_accept, n_reject, n_timeout);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
